// ===== src/equirect_env_map_sampler_core_macros.svh =====
// ---------------------------------------------------------------------------
// equirect env map sampler assertion macros
// Concurrent check helpers, compiled away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef EQUIRECT_ENV_MAP_SAMPLER_CORE_MACROS_SVH
`define EQUIRECT_ENV_MAP_SAMPLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define EMSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("emss check failed");
// antecedent implies consequent in the next cycle
`define EMSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("emss check failed");
`else
`define EMSS_ASSERT_SAME(label, ante, cons)
`define EMSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/emss_pkg.sv =====
// ---------------------------------------------------------------------------
// emss_pkg
// Shared constants, types and step functions of the env map sampler.
// ---------------------------------------------------------------------------
package emss_pkg;

  // map geometry and store
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CHAN_W     = 16;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int COORD_W    = 17;
  localparam int DIR_W      = 16;

  // command codes
  localparam logic [1:0] CMD_SAMPLE_UV  = 2'd0;
  localparam logic [1:0] CMD_WRITE      = 2'd1;
  localparam logic [1:0] CMD_SAMPLE_DIR = 2'd2;
  localparam logic [1:0] CMD_NOP        = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PRESENT = 2'd2;

  // unit length in q1.14
  localparam logic signed [DIR_W-1:0] Q14_ONE     = 16'sd16384;
  localparam logic signed [DIR_W-1:0] Q14_NEG_ONE = -16'sd16384;

  // square root unit
  localparam int SQRT_STEPS     = 15;
  localparam int SQ_PER_STAGE   = 3;
  localparam int SQRT_STAGES    = 1 + SQRT_STEPS / SQ_PER_STAGE;
  localparam int SQ_TOP         = 2 * (SQRT_STEPS - 1);
  localparam int SQ_W           = SQ_TOP + 2;
  localparam int ROOT_W         = 15;

  // cordic unit
  localparam int CORDIC_STEPS   = 24;
  localparam int CS_PER_STAGE   = 3;
  localparam int CORDIC_STAGES  = CORDIC_STEPS / CS_PER_STAGE;
  localparam int CW             = 33;
  localparam int AW             = 34;
  localparam int EW             = AW + 2;

  // pipeline stage positions
  localparam int ST_CORDIC0 = SQRT_STAGES;
  localparam int ST_MAP     = ST_CORDIC0 + CORDIC_STAGES;
  localparam int ST_INDEX   = ST_MAP + 1;
  localparam int ST_MEM     = ST_INDEX + 1;
  localparam int NSTG       = ST_MEM + 1;

  // angles in 2^-32 turn
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'd1 << 30);
  localparam logic signed [EW-1:0] HALF_TURN    = EW'(64'd1 << 31);
  localparam logic signed [EW-1:0] FULL_TURN    = EW'(64'd1 << 32);

  localparam logic [31:0] ARC_TABLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } texel_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  // one vectoring rotation
  function automatic cordic_t cordic_step(cordic_t s, int k);
    cordic_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [AW-1:0] arc;
    dx  = s.y >>> k;
    dy  = s.x >>> k;
    arc = $signed({2'b00, ARC_TABLE[k]});
    if (!s.y[CW-1]) begin
      r.x   = s.x + dx;
      r.y   = s.y - dy;
      r.ang = s.ang + arc;
    end else begin
      r.x   = s.x - dx;
      r.y   = s.y + dy;
      r.ang = s.ang - arc;
    end
    return r;
  endfunction

  // one digit of the floor square root
  function automatic sqrt_t sqrt_step(sqrt_t s, int n);
    sqrt_t r;
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    bitv  = SQ_W'(1) << (SQ_TOP - 2 * n);
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // angle to q1.16 coordinate with clamp to [0, 1]
  function automatic logic [COORD_W-1:0] angle_to_q16(logic signed [EW-1:0] a);
    logic [COORD_W-1:0] q;
    if (a < 0) begin
      q = '0;
    end else if (a > FULL_TURN) begin
      q = FULL_TURN[16 +: COORD_W];
    end else begin
      q = a[16 +: COORD_W];
    end
    return q;
  endfunction

endpackage

// ===== src/emss_channels.sv =====
// ---------------------------------------------------------------------------
// emss channels
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface emss_item_if;
  import emss_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [COORD_W-1:0]       tex_u;
  logic [COORD_W-1:0]       tex_v;
  logic signed [DIR_W-1:0]  dir_x;
  logic signed [DIR_W-1:0]  dir_y;
  logic signed [DIR_W-1:0]  dir_z;
  logic [CHAN_W-1:0]        texel_red;
  logic [CHAN_W-1:0]        texel_green;
  logic [CHAN_W-1:0]        texel_blue;

  modport source (output valid, command, tex_u, tex_v, dir_x, dir_y, dir_z,
                  texel_red, texel_green, texel_blue, input ready);
  modport sink (input valid, command, tex_u, tex_v, dir_x, dir_y, dir_z,
                texel_red, texel_green, texel_blue, output ready);
endinterface

interface emss_result_if;
  import emss_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== src/equirect_env_map_sampler_core.sv =====
// ---------------------------------------------------------------------------
// equirect_env_map_sampler_core
// Nearest texel lookup in an equirectangular environment map.
// ---------------------------------------------------------------------------
// Takes one command beat per cycle while no stage is held and returns a result beat
// for coordinate and direction samples; texel writes give no beat. The path is
// a six stage square root (z*z then three root digits a stage), two eight
// stage cordic units running side by side for yaw and pitch, a stage that
// turns angles into coordinates and scales them by the map size, an address
// stage, and the texel memory read. A full stage holds while its successor cannot
// take its beat, so bubbles close up and a waiting result blocks only the stages behind
// it. The store (131072 texels of three 16 bit channels) is not cleared at
// reset; reading a texel that was never written returns undefined data.
// Configuration must only be written with the pipeline empty.
`include "equirect_env_map_sampler_core_macros.svh"

module equirect_env_map_sampler_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [emss_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [emss_pkg::CFG_W-1:0]         wr_data,
  emss_item_if.sink                          item,
  emss_result_if.source                      result
);
  import emss_pkg::*;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [COORD_W-1:0]      u;
    logic [COORD_W-1:0]      v;
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;
    texel_t                  texel;
  } side_t;

  // configuration
  logic [WIDTH_W-1:0]  map_width;
  logic [HEIGHT_W-1:0] map_height;
  logic                map_present;
  logic [WIDTH_W-1:0]  w_sat;
  logic [HEIGHT_W-1:0] h_sat;
  logic [WIDTH_W-1:0]  w_last;
  logic [HEIGHT_W-1:0] h_last;

  // pipeline control
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  logic            has_result;

  // payload
  side_t                    side [ST_MAP];
  logic signed [DIR_W-1:0]  z_sat;
  logic [ROOT_W-1:0]        root;
  logic signed [AW-1:0]     yaw;
  logic signed [AW-1:0]     pitch;
  logic [COORD_W-1:0]       u_sel;
  logic [COORD_W-1:0]       v_sel;
  logic [COORD_W+WIDTH_W-1:0]  prod_u;
  logic [COORD_W+HEIGHT_W-1:0] prod_v;
  logic [1:0]               cmd14;
  texel_t                   texel14;
  logic                     zero14;
  logic [WIDTH_W:0]         col_raw;
  logic [HEIGHT_W:0]        row_raw;
  logic [COL_W-1:0]         col;
  logic [ROW_W-1:0]         row;
  logic [ADDR_W:0]          lin;
  logic [1:0]               cmd15;
  texel_t                   texel15;
  logic                     zero15;
  logic [ADDR_W-1:0]        addr15;
  logic [1:0]               cmd16;
  logic                     zero16;
  texel_t                   rd_texel;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= WIDTH_W'(MAX_WIDTH);
      map_height  <= HEIGHT_W'(MAX_HEIGHT);
      map_present <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MAP_WIDTH:   map_width   <= wr_data[WIDTH_W-1:0];
        REG_MAP_HEIGHT:  map_height  <= wr_data[HEIGHT_W-1:0];
        REG_MAP_PRESENT: map_present <= wr_data[0];
        default: ;
      endcase
    end
  end

  // map size saturated to the store
  always_comb begin
    w_sat = map_width;
    if (map_width == '0) w_sat = WIDTH_W'(1);
    else if (map_width > WIDTH_W'(MAX_WIDTH)) w_sat = WIDTH_W'(MAX_WIDTH);
    h_sat = map_height;
    if (map_height == '0) h_sat = HEIGHT_W'(1);
    else if (map_height > HEIGHT_W'(MAX_HEIGHT)) h_sat = HEIGHT_W'(MAX_HEIGHT);
    w_last = w_sat - WIDTH_W'(1);
    h_last = h_sat - HEIGHT_W'(1);
  end

  // stage hold chain, output stage frees itself when it has no beat
  assign has_result = (cmd16 == CMD_SAMPLE_UV) || (cmd16 == CMD_SAMPLE_DIR);
  always_comb begin
    rdy[NSTG] = result.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      if (k == ST_MEM) rdy[k] = !(vld[k] && has_result) || rdy[k+1];
      else             rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign item.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= item.valid && item.ready;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // z saturated to the unit range
  always_comb begin
    z_sat = item.dir_z;
    if (item.dir_z > Q14_ONE) z_sat = Q14_ONE;
    else if (item.dir_z < Q14_NEG_ONE) z_sat = Q14_NEG_ONE;
  end

  // side data through the angle stages
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side[0].cmd   <= item.command;
      side[0].u     <= item.tex_u;
      side[0].v     <= item.tex_v;
      side[0].x     <= item.dir_x;
      side[0].y     <= item.dir_y;
      side[0].z     <= z_sat;
      side[0].texel <= '{red: item.texel_red, green: item.texel_green,
                         blue: item.texel_blue};
    end
    for (int k = 1; k < ST_MAP; k++) begin
      if (rdy[k]) side[k] <= side[k-1];
    end
  end

  emss_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (rdy[SQRT_STAGES-1:0]),
    .z    (z_sat),
    .root (root)
  );

  emss_cordic_pipe u_yaw (
    .clk   (clk),
    .en    (rdy[ST_MAP-1:ST_CORDIC0]),
    .xin   ((DIR_W+1)'(side[ST_CORDIC0-1].x)),
    .yin   ((DIR_W+1)'(side[ST_CORDIC0-1].y)),
    .angle (yaw)
  );

  emss_cordic_pipe u_pitch (
    .clk   (clk),
    .en    (rdy[ST_MAP-1:ST_CORDIC0]),
    .xin   ($signed({2'b00, root})),
    .yin   ((DIR_W+1)'(side[ST_CORDIC0-1].z)),
    .angle (pitch)
  );

  // angles to coordinates, scale by the map size
  always_comb begin
    u_sel = side[ST_MAP-1].u;
    v_sel = side[ST_MAP-1].v;
    if (side[ST_MAP-1].cmd == CMD_SAMPLE_DIR) begin
      u_sel = angle_to_q16(HALF_TURN - EW'(yaw));
      v_sel = angle_to_q16((EW'(pitch) <<< 1) + HALF_TURN);
    end
    prod_u = (COORD_W+WIDTH_W)'(u_sel) * (COORD_W+WIDTH_W)'(w_sat);
    prod_v = (COORD_W+HEIGHT_W)'(v_sel) * (COORD_W+HEIGHT_W)'(h_sat);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_MAP]) begin
      cmd14   <= side[ST_MAP-1].cmd;
      texel14 <= side[ST_MAP-1].texel;
      zero14  <= (side[ST_MAP-1].cmd == CMD_SAMPLE_DIR) && !map_present;
      col_raw <= prod_u[COORD_W+WIDTH_W-1:16];
      row_raw <= prod_v[COORD_W+HEIGHT_W-1:16];
    end
  end

  // clamp to the last column and row, form the address
  always_comb begin
    col = (col_raw > (WIDTH_W+1)'(w_last)) ? w_last[COL_W-1:0] : col_raw[COL_W-1:0];
    row = (row_raw > (HEIGHT_W+1)'(h_last)) ? h_last[ROW_W-1:0] : row_raw[ROW_W-1:0];
    lin = (ADDR_W+1)'(row) * (ADDR_W+1)'(w_sat) + (ADDR_W+1)'(col);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_INDEX]) begin
      cmd15   <= cmd14;
      texel15 <= texel14;
      zero15  <= zero14;
      addr15  <= lin[ADDR_W-1:0];
    end
  end

  // texel store access
  emss_texel_mem u_mem (
    .clk   (clk),
    .en    (rdy[ST_MEM]),
    .we    (vld[ST_INDEX] && (cmd15 == CMD_WRITE)),
    .addr  (addr15),
    .wdata (texel15),
    .rdata (rd_texel)
  );

  always_ff @(posedge clk) begin
    if (rdy[ST_MEM]) begin
      cmd16  <= cmd15;
      zero16 <= zero15;
    end
  end

  // result beat
  assign result.valid = vld[ST_MEM] && has_result;
  assign result.red   = zero16 ? '0 : rd_texel.red;
  assign result.green = zero16 ? '0 : rd_texel.green;
  assign result.blue  = zero16 ? '0 : rd_texel.blue;

  // checks
  `EMSS_ASSERT_SAME(a_ready_when_sink_ready, result.ready, item.ready)
  `EMSS_ASSERT_SAME(a_write_gives_no_beat, vld[ST_MEM] && (cmd16 == CMD_WRITE), !result.valid)
  `EMSS_ASSERT_NEXT(a_stalled_addr_holds, vld[ST_INDEX] && !rdy[ST_INDEX], vld[ST_INDEX] && $stable(addr15))

endmodule

// ===== src/emss_sqrt_pipe.sv =====
// ---------------------------------------------------------------------------
// emss_sqrt_pipe
// Pipelined cosine term: floor sqrt of (1 - z*z) in q1.14, three digits a stage.
// ---------------------------------------------------------------------------
module emss_sqrt_pipe (
  input  logic                                  clk,
  input  logic [emss_pkg::SQRT_STAGES-1:0]      en,
  input  logic signed [emss_pkg::DIR_W-1:0]     z,
  output logic [emss_pkg::ROOT_W-1:0]           root
);
  import emss_pkg::*;

  logic signed [2*DIR_W-1:0] zsq;
  sqrt_t                     st [SQRT_STAGES];

  // square of the saturated z
  assign zsq = z * z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].rem  <= (SQ_W'(1) << SQ_TOP) - zsq[SQ_W-1:0];
      st[0].root <= '0;
    end
  end

  // digit stages
  for (genvar s = 1; s < SQRT_STAGES; s++) begin : g_stage
    sqrt_t nxt;
    always_comb begin
      nxt = st[s-1];
      for (int t = 0; t < SQ_PER_STAGE; t++) begin
        nxt = sqrt_step(nxt, (s - 1) * SQ_PER_STAGE + t);
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) st[s] <= nxt;
    end
  end

  assign root = st[SQRT_STAGES-1].root[ROOT_W-1:0];

endmodule

// ===== src/emss_cordic_pipe.sv =====
// ---------------------------------------------------------------------------
// emss_cordic_pipe
// Unrolled vectoring cordic for atan2, three rotations a stage.
// ---------------------------------------------------------------------------
module emss_cordic_pipe (
  input  logic                                  clk,
  input  logic [emss_pkg::CORDIC_STAGES-1:0]    en,
  input  logic signed [emss_pkg::DIR_W:0]       xin,
  input  logic signed [emss_pkg::DIR_W:0]       yin,
  output logic signed [emss_pkg::AW-1:0]        angle
);
  import emss_pkg::*;

  cordic_t              st [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] zero_q;
  cordic_t              pre;
  cordic_t              first;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  // scale and fold the left half plane by a quarter turn
  always_comb begin
    xs = CW'(xin) <<< 14;
    ys = CW'(yin) <<< 14;
    pre.x   = xs;
    pre.y   = ys;
    pre.ang = '0;
    if (xs[CW-1]) begin
      if (!ys[CW-1]) begin
        pre.x   = ys;
        pre.y   = -xs;
        pre.ang = QUARTER_TURN;
      end else begin
        pre.x   = -ys;
        pre.y   = xs;
        pre.ang = -QUARTER_TURN;
      end
    end
    first = pre;
    for (int t = 0; t < CS_PER_STAGE; t++) begin
      first = cordic_step(first, t);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0]     <= first;
      zero_q[0] <= (xin == '0) && (yin == '0);
    end
  end

  // rotation stages
  for (genvar s = 1; s < CORDIC_STAGES; s++) begin : g_stage
    cordic_t nxt;
    always_comb begin
      nxt = st[s-1];
      for (int t = 0; t < CS_PER_STAGE; t++) begin
        nxt = cordic_step(nxt, s * CS_PER_STAGE + t);
      end
    end
    always_ff @(posedge clk) begin
      if (en[s]) begin
        st[s]     <= nxt;
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  // zero vector has angle zero
  assign angle = zero_q[CORDIC_STAGES-1] ? '0 : st[CORDIC_STAGES-1].ang;

endmodule

// ===== src/emss_texel_mem.sv =====
// ---------------------------------------------------------------------------
// emss_texel_mem
// Single port texel store with registered read data.
// ---------------------------------------------------------------------------
module emss_texel_mem (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          we,
  input  logic [emss_pkg::ADDR_W-1:0]   addr,
  input  emss_pkg::texel_t              wdata,
  output emss_pkg::texel_t              rdata
);
  import emss_pkg::*;

  texel_t mem [DEPTH];

  // one access per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end

endmodule

// ===== tb/sv/equirect_env_map_sampler_core_tb.sv =====
// ---------------------------------------------------------------------------
// equirect_env_map_sampler_core_tb
// Self-checking bench: seeds the texel store, then runs directed and random
// command beats over several map settings against a cycle-free predictor.
// ---------------------------------------------------------------------------
module equirect_env_map_sampler_core_tb;
  import emss_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 24;

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  emss_item_if   item_bus ();
  emss_result_if res_bus ();

  equirect_env_map_sampler_core u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (item_bus),
    .result   (res_bus)
  );

  // predictor state
  texel_t texel_mem [DEPTH];
  bit written [DEPTH];
  int unsigned map_w;
  int unsigned map_h;
  bit map_on;
  texel_t expected_texels [$];
  int fail_count = 0;
  bit idle_on;
  longint unsigned cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // signed angle of (x, y) in 2^-32 turn, vectoring cordic
  function automatic longint angle_of(longint y_in, longint x_in);
    longint xa;
    longint ya;
    longint ang;
    longint t;
    longint dx;
    longint dy;
    xa = x_in;
    ya = y_in;
    ang = 0;
    if (xa == 0 && ya == 0) return 0;
    xa = xa * 16384;
    ya = ya * 16384;
    if (xa < 0) begin
      t = xa;
      if (ya >= 0) begin
        xa = ya; ya = -t; ang = longint'(1) << 30;
      end else begin
        xa = -ya; ya = t; ang = -(longint'(1) << 30);
      end
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = ya >>> k;
      dy = xa >>> k;
      if (ya >= 0) begin
        xa += dx; ya -= dy; ang += longint'(ARC_TABLE[k]);
      end else begin
        xa -= dx; ya += dy; ang -= longint'(ARC_TABLE[k]);
      end
    end
    return ang;
  endfunction

  // floor square root
  function automatic longint floor_sqrt(longint unsigned r_in);
    longint unsigned r;
    longint unsigned res;
    longint unsigned b;
    r = r_in;
    res = 0;
    b = longint'(1) << 62;
    while (b > r) b >>= 2;
    while (b != 0) begin
      if (r >= res + b) begin
        r -= res + b; res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [COORD_W-1:0] turn_to_coord(longint a);
    if (a < 0) a = 0;
    if (a > (longint'(1) << 32)) a = longint'(1) << 32;
    return COORD_W'(a >> 16);
  endfunction

  // store address of the texel under a coordinate
  function automatic int unsigned texel_addr(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    longint unsigned w;
    longint unsigned h;
    longint unsigned i;
    longint unsigned j;
    w = map_w; h = map_h;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    i = (longint'(u) * w) >> 16;
    j = (longint'(v) * h) >> 16;
    if (i > w - 1) i = w - 1;
    if (j > h - 1) j = h - 1;
    return int'(j * w + i);
  endfunction

  // coordinate that a command reads from the store; returns zero when it reads nothing
  function automatic bit read_coord(logic [1:0] cmd, logic [COORD_W-1:0] u,
                                    logic [COORD_W-1:0] v, logic signed [DIR_W-1:0] x,
                                    logic signed [DIR_W-1:0] y, logic signed [DIR_W-1:0] z,
                                    output logic [COORD_W-1:0] su,
                                    output logic [COORD_W-1:0] sv);
    longint zc;
    longint c;
    longint yaw;
    longint pitch;
    su = u;
    sv = v;
    if (cmd == CMD_SAMPLE_UV) return 1'b1;
    if (cmd != CMD_SAMPLE_DIR || !map_on) return 1'b0;
    zc = longint'(z);
    if (zc > 16384) zc = 16384;
    if (zc < -16384) zc = -16384;
    c = floor_sqrt(longint'(16384 * 16384) - zc * zc);
    yaw = angle_of(longint'(y), longint'(x));
    pitch = angle_of(zc, c);
    su = turn_to_coord((longint'(1) << 31) - yaw);
    sv = turn_to_coord(2 * pitch + (longint'(1) << 31));
    return 1'b1;
  endfunction

  // apply one accepted command beat to the predictor
  task automatic apply_command(logic [1:0] cmd, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                               logic signed [DIR_W-1:0] x, logic signed [DIR_W-1:0] y,
                               logic signed [DIR_W-1:0] z, texel_t wt);
    logic [COORD_W-1:0] su;
    logic [COORD_W-1:0] sv;
    if (cmd == CMD_WRITE) begin
      texel_mem[texel_addr(u, v)] = wt;
      written[texel_addr(u, v)] = 1'b1;
    end else if (read_coord(cmd, u, v, x, y, z, su, sv)) begin
      expected_texels.push_back(texel_mem[texel_addr(su, sv)]);
    end else if (cmd == CMD_SAMPLE_DIR) begin
      expected_texels.push_back('0);
    end
  endtask

  function automatic texel_t rand_texel;
    texel_t t;
    t.red = 16'($urandom); t.green = 16'($urandom); t.blue = 16'($urandom);
    return t;
  endfunction

  // send one command beat and wait for acceptance
  task automatic send_beat(logic [1:0] cmd, logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                           logic signed [DIR_W-1:0] x, logic signed [DIR_W-1:0] y,
                           logic signed [DIR_W-1:0] z, texel_t wt);
    logic [COORD_W-1:0] su;
    logic [COORD_W-1:0] sv;
    // a sample only reads texels that hold written data
    if (read_coord(cmd, u, v, x, y, z, su, sv) && !written[texel_addr(su, sv)])
      send_beat(CMD_WRITE, su, sv, '0, '0, '0, rand_texel());
    while (idle_on && $urandom_range(99) < 25) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.command     <= cmd;
    item_bus.tex_u       <= u;
    item_bus.tex_v       <= v;
    item_bus.dir_x       <= x;
    item_bus.dir_y       <= y;
    item_bus.dir_z       <= z;
    item_bus.texel_red   <= wt.red;
    item_bus.texel_green <= wt.green;
    item_bus.texel_blue  <= wt.blue;
    do @(posedge clk); while (!item_bus.ready);
    apply_command(cmd, u, v, x, y, z, wt);
  endtask

  // drop valid, let all results arrive and the pipeline settle
  task automatic drain;
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_texels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // program the three map registers while idle
  task automatic set_map(int unsigned w, int unsigned h, bit on);
    drain();
    wr_en <= 1'b1; wr_index <= REG_MAP_WIDTH; wr_data <= CFG_W'(w);
    @(posedge clk);
    wr_index <= REG_MAP_HEIGHT; wr_data <= CFG_W'(h);
    @(posedge clk);
    wr_index <= REG_MAP_PRESENT; wr_data <= CFG_W'(on);
    @(posedge clk);
    wr_en <= 1'b0;
    map_w = w & 10'h3FF;
    map_h = h & 9'h1FF;
    map_on = on;
  endtask

  function automatic logic signed [DIR_W-1:0] rand_dir;
    if ($urandom_range(9) == 0) return DIR_W'($urandom);
    return DIR_W'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord;
    case ($urandom_range(9))
      0: return COORD_W'($urandom);
      1: return COORD_W'(65536);
      2: return '0;
      default: return COORD_W'($urandom_range(65535));
    endcase
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    texel_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_texels.size() == 0) begin
        $error("unexpected result beat red=%h green=%h blue=%h",
               res_bus.red, res_bus.green, res_bus.blue);
        fail_count++;
      end else begin
        want = expected_texels.pop_front();
        if (res_bus.red !== want.red) begin
          $error("red expected %h actual %h", want.red, res_bus.red);
          fail_count++;
        end
        if (res_bus.green !== want.green) begin
          $error("green expected %h actual %h", want.green, res_bus.green);
          fail_count++;
        end
        if (res_bus.blue !== want.blue) begin
          $error("blue expected %h actual %h", want.blue, res_bus.blue);
          fail_count++;
        end
      end
    end
    res_bus.ready <= !rst && (idle_on ? ($urandom_range(99) >= 25) : 1'b1);
  end

  // back to back writes over a coarse grid of the full map
  task automatic test_fill_store;
    idle_on = 1'b0;
    for (int j = 0; j < 16; j++)
      for (int i = 0; i < 16; i++)
        send_beat(CMD_WRITE, COORD_W'(i << 12), COORD_W'(j << 12), '0, '0, '0, rand_texel());
  endtask

  // edges of every field, every command, absent map
  task automatic test_directed;
    idle_on = 1'b1;
    set_map(512, 256, 1'b1);
    send_beat(CMD_WRITE, '0, '0, '0, '0, '0, '0);
    send_beat(CMD_WRITE, COORD_W'(65536), COORD_W'(65536), '0, '0, '0, '1);
    send_beat(CMD_SAMPLE_UV, '0, '0, '0, '0, '0, '0);
    send_beat(CMD_SAMPLE_UV, COORD_W'(65535), COORD_W'(65535), '0, '0, '0, '0);
    send_beat(CMD_SAMPLE_UV, COORD_W'(65536), COORD_W'(65536), '0, '0, '0, '0);
    send_beat(CMD_SAMPLE_UV, '1, '1, '1, '1, '1, '1);
    send_beat(CMD_SAMPLE_DIR, '0, '0, '0, '0, '0, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, Q14_ONE, '0, '0, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, Q14_NEG_ONE, '0, '0, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, '0, Q14_ONE, '0, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, '0, Q14_NEG_ONE, '0, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, Q14_NEG_ONE, '0, '0, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, '0, '0, Q14_ONE, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, '0, '0, Q14_NEG_ONE, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, 16'sh8000, 16'sh8000, 16'sh8000, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, 16'sh8000, '0, '0, '0);
    send_beat(CMD_NOP, '1, '1, '1, '1, '1, '1);
    send_beat(CMD_SAMPLE_UV, '0, '0, '0, '0, '0, '0);
    set_map(512, 256, 1'b0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, Q14_ONE, '0, '0, '0);
    send_beat(CMD_SAMPLE_DIR, '0, '0, '0, '0, Q14_ONE, '0);
    send_beat(CMD_SAMPLE_UV, COORD_W'(32768), COORD_W'(32768), '0, '0, '0, '0);
  endtask

  // random command mix under one map setting
  task automatic test_random_map(int unsigned w, int unsigned h, bit on, int n, bit idles);
    int pick;
    logic [1:0] cmd;
    set_map(w, h, on);
    idle_on = idles;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 35) cmd = CMD_SAMPLE_UV;
      else if (pick < 55) cmd = CMD_WRITE;
      else if (pick < 95) cmd = CMD_SAMPLE_DIR;
      else cmd = CMD_NOP;
      send_beat(cmd, rand_coord(), rand_coord(), rand_dir(), rand_dir(), rand_dir(),
                rand_texel());
    end
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    item_bus.valid = 1'b0;
    item_bus.command = '0;
    item_bus.tex_u = '0;
    item_bus.tex_v = '0;
    item_bus.dir_x = '0;
    item_bus.dir_y = '0;
    item_bus.dir_z = '0;
    item_bus.texel_red = '0;
    item_bus.texel_green = '0;
    item_bus.texel_blue = '0;
    idle_on = 1'b0;
    map_w = 512;
    map_h = 256;
    map_on = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_store();
    test_directed();
    test_random_map(512, 256, 1'b1, 120, 1'b1);
    test_random_map(1, 1, 1'b1, 100, 1'b1);
    test_random_map(37, 200, 1'b1, 120, 1'b0);
    test_random_map(0, 0, 1'b1, 80, 1'b1);
    test_random_map(1023, 511, 1'b1, 120, 1'b1);
    test_random_map(300, 17, 1'b0, 100, 1'b1);
    test_random_map(512, 1, 1'b1, 80, 1'b1);
    test_random_map(1, 256, 1'b1, 80, 1'b1);
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
